// ===== src/srt_pkg.sv =====
// ----------------------------------------------------------------------------
// srt_pkg
// Types, codes and helpers shared by the survey request tracker.
// ----------------------------------------------------------------------------
`default_nettype none

package srt_pkg;

	localparam int unsigned ID_W       = 32;
	localparam int unsigned DEADLINE_W = 31;
	localparam int unsigned CFG_DATA_W = 32;

	localparam logic [ID_W-1:0]       ID_TOP_BIT     = 32'h8000_0000;
	localparam logic [DEADLINE_W-1:0] DEADLINE_RESET = 31'd1000;
	localparam logic [ID_W-1:0]       ID_RESET       = '0;

	// Event codes carried in the func field.
	localparam logic [2:0] FN_START   = 3'd0;
	localparam logic [2:0] FN_SEND    = 3'd1;
	localparam logic [2:0] FN_RECV    = 3'd2;
	localparam logic [2:0] FN_TIMEOUT = 3'd3;
	localparam logic [2:0] FN_TSTOP   = 3'd4;
	localparam logic [2:0] FN_STOP    = 3'd5;
	localparam logic [2:0] FN_QUERY   = 3'd6;

	// Status codes of a result.
	localparam logic [2:0] ST_OK       = 3'd0;
	localparam logic [2:0] ST_BLOCK    = 3'd1;
	localparam logic [2:0] ST_TIMEDOUT = 3'd2;
	localparam logic [2:0] ST_NOSURVEY = 3'd3;
	localparam logic [2:0] ST_STALE    = 3'd4;
	localparam logic [2:0] ST_BAD      = 3'd5;

	// Timer commands.
	localparam logic [1:0] TC_NONE  = 2'd0;
	localparam logic [1:0] TC_START = 2'd1;
	localparam logic [1:0] TC_STOP  = 2'd2;

	typedef enum logic [0:0] {
		CFG_DEADLINE = 1'b0,
		CFG_INIT_ID  = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		S_IDLE       = 3'd0,
		S_PASSIVE    = 3'd1,
		S_ACTIVE     = 3'd2,
		S_CANCELLING = 3'd3,
		S_STOP_TIMER = 3'd4,
		S_STOPPING   = 3'd5
	} fsm_state_t;

	typedef struct packed {
		logic [2:0]      func;
		logic            lower_can_send;
		logic            lower_readable;
		logic            response_present;
		logic            response_header_ok;
		logic [ID_W-1:0] response_id;
		logic            timer_idle;
	} srt_req_t;

	typedef struct packed {
		logic [2:0]            status;
		logic [ID_W-1:0]       survey_tag;
		logic                  transmit;
		logic [1:0]            timer_command;
		logic [DEADLINE_W-1:0] timer_delay;
		logic                  in_progress;
		logic                  readable_hint;
		logic                  stopped;
	} srt_rsp_t;

	// A survey is running, being cancelled, or waiting for its timer to stop.
	function automatic logic srt_busy(input fsm_state_t s);
		return (s == S_ACTIVE) || (s == S_CANCELLING) || (s == S_STOP_TIMER);
	endfunction

	function automatic logic [ID_W-1:0] srt_next_id(input logic [ID_W-1:0] id);
		return (id + ID_W'(1)) | ID_TOP_BIT;
	endfunction

endpackage

`default_nettype wire

// ===== src/survey_request_tracker.sv =====
// ----------------------------------------------------------------------------
// survey_request_tracker
// Control of a surveyor keeping one survey outstanding at a time.
// ----------------------------------------------------------------------------
// Events arrive on the req channel (valid/stall), one transaction per event,
// and each produces exactly one result transaction on the rsp channel.
// An event is captured in an input register, evaluated against the tracker
// state in combinational logic, and its result lands in an output register;
// rsp_valid rises when the output register loads it, and one event is
// taken every cycle while the receiver keeps rsp_stall low. When the receiver
// stalls, the result holds in the output register and one more event can
// sit in the input register; after that req_stall rises until the result
// is taken. The cfg channel writes the deadline (index 0) and the starting
// survey ID (index 1, which also loads the current ID); it is always ready,
// but must be written only while no event is in flight; the tracker does
// not enforce this. Reset empties both registers and returns the tracker
// to idle with a deadline of 1000 ticks, a survey ID of zero and no pending timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module survey_request_tracker
	import srt_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  req_valid,
	output logic                       req_stall,
	input  wire srt_req_t              req,
	output logic                       rsp_valid,
	input  wire logic                  rsp_stall,
	output srt_rsp_t                   rsp,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire cfg_index_t            cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	srt_req_t              req_s1;
	logic                  req_v_s1;
	srt_rsp_t              rsp_s2;
	logic                  rsp_v_s2;
	fsm_state_t            state_q;
	fsm_state_t            state_d;
	logic [ID_W-1:0]       cur_id_q;
	logic [ID_W-1:0]       cur_id_d;
	logic                  tmo_flag_q;
	logic                  tmo_flag_d;
	logic [DEADLINE_W-1:0] deadline_q;
	logic                  advance;
	logic                  cfg_wr;
	logic                  busy_now;
	srt_rsp_t              result;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid && cfg_ready;
	assign advance   = req_v_s1 && (!rsp_v_s2 || !rsp_stall);
	assign req_stall = req_v_s1 && !advance;
	assign rsp_valid = rsp_v_s2;
	assign rsp       = rsp_s2;
	assign busy_now  = srt_busy(state_q);

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (req_s1.func)
			FN_START: begin
				if (state_q == S_IDLE) begin
					state_d = S_PASSIVE;
				end
			end
			FN_SEND: begin
				if (busy_now) begin
					if (req_s1.lower_can_send) begin
						state_d = S_CANCELLING;
					end
				end else if (state_q == S_PASSIVE) begin
					state_d = S_ACTIVE;
				end
			end
			FN_TIMEOUT, FN_TSTOP: begin
				if (state_q == S_STOPPING) begin
					if (req_s1.timer_idle) begin
						state_d = S_IDLE;
					end
				end else if (req_s1.func == FN_TIMEOUT && state_q == S_ACTIVE) begin
					state_d = S_STOP_TIMER;
				end else if (req_s1.func == FN_TSTOP && state_q == S_CANCELLING) begin
					state_d = S_ACTIVE;
				end else if (req_s1.func == FN_TSTOP && state_q == S_STOP_TIMER) begin
					state_d = S_PASSIVE;
				end
			end
			FN_STOP: begin
				if (state_q != S_IDLE && state_q != S_STOPPING) begin
					state_d = req_s1.timer_idle ? S_IDLE : S_STOPPING;
				end
			end
			default: begin
				state_d = state_q;
			end
		endcase
	end

	// Result fields, survey ID and timeout flag.
	always_comb begin
		result               = '0;
		result.status        = ST_OK;
		result.timer_command = TC_NONE;
		cur_id_d             = cur_id_q;
		tmo_flag_d           = tmo_flag_q;
		unique case (req_s1.func)
			FN_START: begin
				if (state_q != S_IDLE) begin
					result.status = ST_BAD;
				end
			end
			FN_SEND: begin
				if (busy_now) begin
					cur_id_d = srt_next_id(cur_id_q);
					if (!req_s1.lower_can_send) begin
						result.status = ST_BLOCK;
					end else if (state_q == S_ACTIVE) begin
						result.timer_command = TC_STOP;
					end
				end else if (state_q == S_PASSIVE) begin
					cur_id_d             = srt_next_id(cur_id_q);
					result.transmit      = 1'b1;
					result.timer_command = TC_START;
				end else begin
					result.status = ST_BAD;
				end
			end
			FN_RECV: begin
				if (!busy_now) begin
					if (tmo_flag_q) begin
						tmo_flag_d    = 1'b0;
						result.status = ST_TIMEDOUT;
					end else begin
						result.status = ST_NOSURVEY;
					end
				end else if (!req_s1.response_present) begin
					result.status = ST_BLOCK;
				end else if (!req_s1.response_header_ok ||
						req_s1.response_id != cur_id_q) begin
					result.status = ST_STALE;
				end
			end
			FN_TIMEOUT, FN_TSTOP: begin
				if (state_q == S_STOPPING) begin
					result.stopped = req_s1.timer_idle;
				end else if (req_s1.func == FN_TIMEOUT && state_q == S_ACTIVE) begin
					result.timer_command = TC_STOP;
					tmo_flag_d           = 1'b1;
				end else if (req_s1.func == FN_TSTOP && state_q == S_CANCELLING) begin
					result.transmit      = 1'b1;
					result.timer_command = TC_START;
				end else if (!(req_s1.func == FN_TSTOP && state_q == S_STOP_TIMER)) begin
					result.status = ST_BAD;
				end
			end
			FN_STOP: begin
				if (state_q == S_IDLE || state_q == S_STOPPING) begin
					result.status = ST_BAD;
				end else begin
					result.timer_command = TC_STOP;
					result.stopped       = req_s1.timer_idle;
				end
			end
			FN_QUERY: begin
				result.readable_hint = req_s1.lower_readable || !busy_now;
			end
			default: begin
				result.status = ST_BAD;
			end
		endcase
		result.survey_tag  = cur_id_d;
		result.timer_delay = (result.timer_command == TC_START) ? deadline_q : '0;
		result.in_progress = srt_busy(state_d);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_v_s1   <= 1'b0;
			rsp_v_s2   <= 1'b0;
			state_q    <= S_IDLE;
			cur_id_q   <= ID_RESET;
			tmo_flag_q <= 1'b0;
			deadline_q <= DEADLINE_RESET;
		end else begin
			if (req_valid && !req_stall) begin
				req_v_s1 <= 1'b1;
			end else if (advance) begin
				req_v_s1 <= 1'b0;
			end
			if (advance) begin
				rsp_v_s2   <= 1'b1;
				state_q    <= state_d;
				cur_id_q   <= cur_id_d;
				tmo_flag_q <= tmo_flag_d;
			end else if (!rsp_stall) begin
				rsp_v_s2 <= 1'b0;
			end
			if (cfg_wr) begin
				unique case (cfg_index)
					CFG_DEADLINE: begin
						deadline_q <= cfg_data[DEADLINE_W-1:0];
					end
					CFG_INIT_ID: begin
						cur_id_q <= cfg_data[ID_W-1:0];
					end
					default: begin
						deadline_q <= deadline_q;
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_s2 <= result;
		end
	end

`ifndef SYNTHESIS
	a_bad_keeps_state: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.status == ST_BAD && !cfg_wr)
		|=> ($stable(state_q) && $stable(cur_id_q)))
		else $error("bad event changed tracker state");

	a_transmit_active: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.transmit) |=> (state_q == S_ACTIVE && rsp.transmit))
		else $error("transmit without entering active");

	a_stopped_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && result.stopped) |=> (state_q == S_IDLE && !rsp.in_progress))
		else $error("shutdown did not return to idle");

	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		req_stall |-> (req_v_s1 && rsp_v_s2 && rsp_stall))
		else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire
